// File: src/pcq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcq_pkg: shared types and constants for the quota accounting table
// Holds command codes, status and event codes, reset quotas and cell types.
// ----------------------------------------------------------------------------
package pcq_pkg;

  localparam int MAX_KINDS = 7;

  typedef enum logic [3:0] {
    ACT_REGISTER   = 4'd0,
    ACT_UNREGISTER = 4'd1,
    ACT_SET_QUOTA  = 4'd2,
    ACT_REQUEST    = 4'd3,
    ACT_RELEASE    = 4'd4,
    ACT_QUERY      = 4'd5,
    ACT_CHECK      = 4'd6,
    ACT_RESET      = 4'd7,
    ACT_SYS_TOTAL  = 4'd8
  } action_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ALREADY   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_KIND  = 3'd4;
  localparam logic [2:0] ST_OVER      = 3'd5;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_EXCEEDED = 2'd1;
  localparam logic [1:0] EV_WARNING  = 2'd2;
  localparam logic [1:0] EV_RESET    = 2'd3;

  localparam logic [2:0] CFG_WARN = 3'd7;

  localparam int MAX_RESULTS = 16;

  localparam logic [31:0] RESET_QUOTA [MAX_KINDS] = '{
    32'd65536, 32'd10000000, 32'd131072, 32'd1048576, 32'd1048576, 32'd8, 32'd4
  };
  localparam logic [6:0] RESET_WARN = 7'd80;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_EXEC, S_MATH, S_SWEEP, S_OUT
  } state_t;

  // Command that the controller broadcasts to every cell.
  typedef struct packed {
    logic        wr_new;    // load defaults into the cell named by sel
    logic        wr_free;   // clear in-use mark of the selected cell
    logic        wr_use;    // write usage for kind
    logic        wr_quota;  // write quota for kind
    logic        clr_use;   // clear all usage of selected cell
    logic [2:0]  kind;
    logic [31:0] value;
    logic [31:0] id;
  } cell_cmd_t;

  typedef struct packed {
    logic        used;
    logic [31:0] id;
    logic [31:0] usage;
    logic [31:0] quota;
  } cell_view_t;

endpackage

// File: src/pcq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcq_cell: one client slot of the table
// Keeps id, in-use mark, usage and quota per kind; passes match and free
// search results along the chain.
// ----------------------------------------------------------------------------
module pcq_cell import pcq_pkg::*; #(
  parameter int KINDS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  cell_cmd_t   cmd,
  input  logic        sel,
  input  logic [31:0] defaults [KINDS],
  input  logic        hit_in,
  input  logic        free_in,
  output logic        hit_out,
  output logic        free_out,
  output logic        match,
  output logic        first_free,
  output cell_view_t  view
);

  logic        used;
  logic [31:0] id;
  logic [31:0] usage [KINDS];
  logic [31:0] quota [KINDS];
  logic [$clog2(KINDS+1)-1:0] kidx;

  assign kidx       = cmd.kind[$clog2(KINDS+1)-1:0];
  assign match      = used && (id == cmd.id);
  assign first_free = !used && !free_in;
  assign hit_out    = hit_in | match;
  assign free_out   = free_in | !used;

  always_comb begin
    view.used  = used;
    view.id    = id;
    view.usage = '0;
    view.quota = '0;
    for (int k = 0; k < KINDS; k++) begin
      if (kidx == k[$clog2(KINDS+1)-1:0]) begin
        view.usage = usage[k];
        view.quota = quota[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (sel && cmd.wr_new) begin
      used <= 1'b1;
    end else if (sel && cmd.wr_free) begin
      used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.wr_new) begin
      id <= cmd.id;
    end
    for (int k = 0; k < KINDS; k++) begin
      if (sel && cmd.wr_new) begin
        usage[k] <= '0;
        quota[k] <= defaults[k];
      end else if (sel && cmd.clr_use) begin
        usage[k] <= '0;
      end else if (sel && kidx == k[$clog2(KINDS+1)-1:0]) begin
        if (cmd.wr_use) begin
          usage[k] <= cmd.value;
        end
        if (cmd.wr_quota) begin
          quota[k] <= cmd.value;
        end
      end
    end
  end

endmodule

// File: src/per_client_quota_accounting_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_client_quota_accounting_table_unit: client quota accounting table
// Row of client slot cells with a command sequencer and system totals.
// ----------------------------------------------------------------------------
// One command is handled at a time: an item is accepted only while the unit is
// idle and no result waits on the output. The result is presented after the
// search of the cell row with the counter read, then the update, then the
// output load; a successful request also passes a step for the warning
// product. The next item is accepted only once the result has been taken, so
// any stall on the output holds back the next command. A reset of all clients
// sweeps the cells one per cycle while the output is free and gives one
// result per client in use, up to MAX_RESULTS.
module per_client_quota_accounting_table_unit import pcq_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int KINDS = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // action[3:0], client_id[35:4], kind[38:36], amount[70:39], zero fill
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], event_client[34:3], event_kind[37:35], event_res[39:38],
  // usage_value[71:40], quota_value[103:72], fits[104], zero fill
  output logic [111:0] m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t state, state_next;

  logic [31:0] defaults [KINDS];
  logic [6:0]  warn;
  logic [31:0] sys_total [MAX_KINDS];

  logic [3:0]  act;
  logic [31:0] cid;
  logic [2:0]  kind;
  logic [31:0] amount;

  logic        hit;
  logic        has_free;
  logic [SW-1:0] hit_slot, free_slot;
  logic [31:0] use_r, quo_r;
  logic [38:0] prod_a;
  logic [38:0] prod_b;
  logic [SW:0] sweep;
  logic [4:0]  nres;

  logic        out_valid;
  logic [2:0]  o_status;
  logic [31:0] o_client;
  logic [2:0]  o_kind;
  logic [1:0]  o_res;
  logic [31:0] o_usage, o_quota;
  logic        o_fits, o_last;

  cell_cmd_t   cmd;
  logic [SLOTS-1:0] sel;
  logic [SLOTS:0]   hit_c, free_c;
  logic [SLOTS-1:0] match, ffree;
  cell_view_t  view [SLOTS];

  logic kind_ok;
  assign kind_ok = {1'b0, kind} < 4'(KINDS);

  assign hit_c[0]  = 1'b0;
  assign free_c[0] = 1'b0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    pcq_cell #(.KINDS(KINDS)) u_cell (
      .clk, .rst, .cmd, .sel(sel[g]), .defaults,
      .hit_in(hit_c[g]), .free_in(free_c[g]),
      .hit_out(hit_c[g+1]), .free_out(free_c[g+1]),
      .match(match[g]), .first_free(ffree[g]), .view(view[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KINDS; k++) begin
        defaults[k] <= RESET_QUOTA[k];
      end
      warn <= RESET_WARN;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WARN) begin
        warn <= cfg_data[6:0];
      end else begin
        for (int k = 0; k < KINDS; k++) begin
          if (cfg_index == k[2:0]) begin
            defaults[k] <= cfg_data;
          end
        end
      end
    end
  end

  assign s_tready = (state == S_IDLE) && !out_valid;
  assign m_tvalid = out_valid;
  assign m_tlast  = o_last;
  assign m_tdata  = {7'd0, o_fits, o_quota, o_usage, o_res, o_kind, o_client, o_status};

  logic [32:0] sum;
  logic        fit;
  logic [31:0] hsel_use, hsel_quo;
  logic [SW-1:0] enc_hit, enc_free;
  logic [31:0] rel_use;
  logic [32:0] tot_sum;
  logic        out_free, out_set;
  logic        sweep_hit, sweep_last, more_used;

  logic [2:0]  e_status;
  logic [31:0] e_client;
  logic [2:0]  e_kind;
  logic [1:0]  e_res;
  logic [31:0] e_usage, e_quota;
  logic        e_fits;

  always_comb begin
    enc_hit  = '0;
    enc_free = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match[i]) enc_hit = enc_hit | i[SW-1:0];
      if (ffree[i]) enc_free = enc_free | i[SW-1:0];
    end
  end

  // Counters of the matching cell are read while the search result settles.
  assign hsel_use = view[enc_hit].usage;
  assign hsel_quo = view[enc_hit].quota;
  assign sum = {1'b0, use_r} + {1'b0, amount};
  assign fit = sum <= {1'b0, quo_r};
  assign rel_use = (amount >= use_r) ? '0 : use_r - amount;
  assign tot_sum = {1'b0, sys_total[kind]} + {1'b0, amount};

  assign out_free  = !out_valid || m_tready;
  assign sweep_hit = view[sweep[SW-1:0]].used && (nres < 5'(MAX_RESULTS));

  always_comb begin
    more_used = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i > int'(sweep) && view[i].used) more_used = 1'b1;
    end
  end

  // A sweep result is the final one when no client in use follows it or the
  // result limit is reached with it.
  assign sweep_last = !more_used || (nres == 5'(MAX_RESULTS - 1));

  always_comb begin
    out_set = 1'b0;
    if (out_free && state == S_SWEEP) out_set = sweep_hit;
    if (out_free && state == S_OUT) out_set = !(act == ACT_RESET && cid == '0 && nres != '0);
  end

  always_comb begin
    e_status = ST_OK;
    e_client = '0;
    e_kind   = '0;
    e_res    = EV_NONE;
    e_usage  = '0;
    e_quota  = '0;
    e_fits   = 1'b0;
    unique case (act)
      ACT_REGISTER: begin
        if (hit) e_status = ST_ALREADY;
        else if (!has_free) e_status = ST_FULL;
      end
      ACT_UNREGISTER: if (!hit) e_status = ST_NOT_FOUND;
      ACT_SET_QUOTA, ACT_REQUEST, ACT_RELEASE, ACT_QUERY, ACT_CHECK: begin
        if (!kind_ok) e_status = ST_BAD_KIND;
        else if (!hit) e_status = ST_NOT_FOUND;
        else if (act == ACT_SET_QUOTA) begin
          e_usage = use_r; e_quota = amount; e_fits = (use_r == '0);
        end else if (act == ACT_REQUEST) begin
          if (!fit) begin
            e_status = ST_OVER; e_client = cid; e_kind = kind;
            e_res = EV_EXCEEDED; e_usage = use_r; e_quota = quo_r;
          end else begin
            e_usage = sum[31:0]; e_quota = quo_r; e_fits = 1'b1;
          end
        end else if (act == ACT_RELEASE) begin
          e_usage = rel_use;
          e_quota = quo_r;
        end else begin
          e_usage = use_r; e_quota = quo_r; e_fits = fit;
        end
      end
      ACT_RESET: begin
        if (cid != '0) begin
          if (!hit) e_status = ST_NOT_FOUND;
          else begin e_client = cid; e_res = EV_RESET; end
        end
      end
      ACT_SYS_TOTAL: begin
        if (!kind_ok) e_status = ST_BAD_KIND;
        else e_usage = sys_total[kind];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.id = cid;
    cmd.kind = kind;
    sel = '0;
    unique case (state)
      S_IDLE: if (s_tvalid && s_tready) state_next = S_LOOK;
      S_LOOK: state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_OUT;
        if (act == ACT_REQUEST && kind_ok && hit && fit) state_next = S_MATH;
        if (act == ACT_RESET && cid == '0) state_next = S_SWEEP;
        if (act == ACT_REGISTER && !hit && has_free) begin
          cmd.wr_new = 1'b1;
          sel[free_slot] = 1'b1;
        end
        if (hit) begin
          if (act == ACT_UNREGISTER) begin
            cmd.wr_free = 1'b1;
            sel[hit_slot] = 1'b1;
          end
          if (act == ACT_RESET && cid != '0) begin
            cmd.clr_use = 1'b1;
            sel[hit_slot] = 1'b1;
          end
          if (kind_ok && act == ACT_SET_QUOTA) begin
            cmd.wr_quota = 1'b1;
            cmd.value = amount;
            sel[hit_slot] = 1'b1;
          end
          if (kind_ok && act == ACT_REQUEST && fit) begin
            cmd.wr_use = 1'b1;
            cmd.value = sum[31:0];
            sel[hit_slot] = 1'b1;
          end
          if (kind_ok && act == ACT_RELEASE) begin
            cmd.wr_use = 1'b1;
            cmd.value = rel_use;
            sel[hit_slot] = 1'b1;
          end
        end
      end
      S_MATH: state_next = S_OUT;
      S_SWEEP: begin
        if (out_free) begin
          cmd.clr_use = 1'b1;
          sel[sweep[SW-1:0]] = 1'b1;
          if (sweep == (SW+1)'(SLOTS - 1)) state_next = S_OUT;
        end
      end
      S_OUT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_set) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < MAX_KINDS; k++) sys_total[k] <= '0;
      sweep <= '0;
      nres <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          act <= s_tdata[3:0];
          cid <= s_tdata[35:4];
          kind <= s_tdata[38:36];
          amount <= s_tdata[70:39];
          sweep <= '0;
          nres <= '0;
        end
        S_LOOK: begin
          hit <= hit_c[SLOTS];
          has_free <= free_c[SLOTS];
          hit_slot <= enc_hit;
          free_slot <= enc_free;
          use_r <= hsel_use;
          quo_r <= hsel_quo;
        end
        S_EXEC: begin
          o_status <= e_status; o_client <= e_client; o_kind <= e_kind; o_res <= e_res;
          o_usage <= e_usage; o_quota <= e_quota; o_fits <= e_fits; o_last <= 1'b1;
          prod_a <= 39'(sum[31:0]) * 39'd100;
          prod_b <= 39'(warn) * 39'(quo_r);
          if (act == ACT_REQUEST && kind_ok && hit && fit) begin
            sys_total[kind] <= tot_sum[32] ? '1 : tot_sum[31:0];
          end else if (act == ACT_RELEASE && kind_ok && hit && amount <= sys_total[kind]) begin
            sys_total[kind] <= sys_total[kind] - amount;
          end
        end
        S_MATH: if (quo_r != '0 && prod_a >= prod_b) begin
          o_client <= cid; o_kind <= kind; o_res <= EV_WARNING;
        end
        S_SWEEP: if (out_free) begin
          sweep <= sweep + 1'b1;
          if (sweep_hit) begin
            nres <= nres + 1'b1;
            o_status <= ST_OK; o_client <= view[sweep[SW-1:0]].id; o_kind <= '0;
            o_res <= EV_RESET; o_usage <= '0; o_quota <= '0; o_fits <= 1'b0;
            o_last <= sweep_last;
          end
          if (sweep == (SW+1)'(SLOTS - 1)) begin
            for (int k = 0; k < MAX_KINDS; k++) sys_total[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed while stalled");

  a_sel_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(sel))
    else $error("more than one cell selected");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[111:105] == '0))
    else $error("result padding not zero");

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_LOOK))
    else $error("accepted item not processed");

endmodule

// File: tb/sv/pcq_quota_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcq_quota_checker: result checker for the quota accounting table
// Watches the command, result and register ports, keeps its own copy of the
// client table and compares every result item with the predicted one.
// ----------------------------------------------------------------------------
module pcq_quota_checker import pcq_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [71:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           pending,
  output int           checked
);

  typedef struct {
    logic [2:0]  status;
    logic [31:0] ev_client;
    logic [2:0]  ev_kind;
    logic [1:0]  ev_res;
    logic [31:0] usage;
    logic [31:0] quota;
    logic        fits;
    logic        last;
  } outcome_t;

  outcome_t    awaited[$];
  logic [31:0] dflt_quota[MAX_KINDS];
  logic [6:0]  warn_pct;
  bit          used[SLOTS];
  logic [31:0] owner[SLOTS];
  logic [31:0] usage[SLOTS][MAX_KINDS];
  logic [31:0] quota[SLOTS][MAX_KINDS];
  logic [31:0] sys_total[MAX_KINDS];

  function automatic int find_client(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (used[i] && owner[i] == id) return i;
    return -1;
  endfunction

  function automatic void expect_outcome(logic [2:0] st, logic [31:0] ec, logic [2:0] ek,
                                         logic [1:0] er, logic [31:0] uv, logic [31:0] qv,
                                         logic ft, logic lst);
    outcome_t o;
    o.status = st; o.ev_client = ec; o.ev_kind = ek; o.ev_res = er;
    o.usage = uv; o.quota = qv; o.fits = ft; o.last = lst;
    awaited.push_back(o);
  endfunction

  // Applies one command to the shadow table and queues the results it causes.
  function automatic void account_command(logic [3:0] act, logic [31:0] id,
                                          logic [2:0] kind, logic [31:0] amount);
    int s;
    int n;
    logic [32:0] sum;
    logic [32:0] tot;
    logic [31:0] cur, quo, nu;
    logic fit;
    longint unsigned lhs, rhs;
    s = find_client(id);
    case (act)
      ACT_REGISTER: begin
        if (s >= 0) begin
          expect_outcome(ST_ALREADY, 0, 0, EV_NONE, 0, 0, 0, 1);
        end else begin
          for (int i = 0; i < SLOTS && s < 0; i++)
            if (!used[i]) s = i;
          if (s < 0) begin
            expect_outcome(ST_FULL, 0, 0, EV_NONE, 0, 0, 0, 1);
          end else begin
            used[s] = 1;
            owner[s] = id;
            for (int k = 0; k < MAX_KINDS; k++) begin
              quota[s][k] = dflt_quota[k];
              usage[s][k] = 0;
            end
            expect_outcome(ST_OK, 0, 0, EV_NONE, 0, 0, 0, 1);
          end
        end
      end
      ACT_UNREGISTER: begin
        if (s < 0) begin
          expect_outcome(ST_NOT_FOUND, 0, 0, EV_NONE, 0, 0, 0, 1);
        end else begin
          used[s] = 0;
          expect_outcome(ST_OK, 0, 0, EV_NONE, 0, 0, 0, 1);
        end
      end
      ACT_SET_QUOTA, ACT_REQUEST, ACT_RELEASE, ACT_QUERY, ACT_CHECK: begin
        if (kind >= MAX_KINDS) begin
          expect_outcome(ST_BAD_KIND, 0, 0, EV_NONE, 0, 0, 0, 1);
        end else if (s < 0) begin
          expect_outcome(ST_NOT_FOUND, 0, 0, EV_NONE, 0, 0, 0, 1);
        end else begin
          cur = usage[s][kind];
          quo = quota[s][kind];
          sum = {1'b0, cur} + {1'b0, amount};
          fit = (sum <= {1'b0, quo});
          if (act == ACT_SET_QUOTA) begin
            quota[s][kind] = amount;
            expect_outcome(ST_OK, 0, 0, EV_NONE, cur, amount, sum <= {1'b0, amount}, 1);
          end else if (act == ACT_REQUEST) begin
            if (!fit) begin
              expect_outcome(ST_OVER, id, kind, EV_EXCEEDED, cur, quo, 0, 1);
            end else begin
              nu = sum[31:0];
              usage[s][kind] = nu;
              tot = {1'b0, sys_total[kind]} + {1'b0, amount};
              sys_total[kind] = tot[32] ? 32'hFFFF_FFFF : tot[31:0];
              lhs = longint'(nu) * 100;
              rhs = longint'(warn_pct) * longint'(quo);
              if (quo != 0 && lhs >= rhs)
                expect_outcome(ST_OK, id, kind, EV_WARNING, nu, quo, 1, 1);
              else
                expect_outcome(ST_OK, 0, 0, EV_NONE, nu, quo, 1, 1);
            end
          end else if (act == ACT_RELEASE) begin
            nu = (amount >= cur) ? 32'd0 : cur - amount;
            usage[s][kind] = nu;
            if (amount <= sys_total[kind]) sys_total[kind] = sys_total[kind] - amount;
            expect_outcome(ST_OK, 0, 0, EV_NONE, nu, quo, 0, 1);
          end else begin
            expect_outcome(ST_OK, 0, 0, EV_NONE, cur, quo, fit, 1);
          end
        end
      end
      ACT_RESET: begin
        if (id == 0) begin
          n = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (used[i]) begin
              for (int k = 0; k < MAX_KINDS; k++) usage[i][k] = 0;
              if (n < MAX_RESULTS) begin
                expect_outcome(ST_OK, owner[i], 0, EV_RESET, 0, 0, 0, 0);
                n++;
              end
            end
          end
          for (int k = 0; k < MAX_KINDS; k++) sys_total[k] = 0;
          if (n == 0) expect_outcome(ST_OK, 0, 0, EV_NONE, 0, 0, 0, 1);
          else awaited[awaited.size() - 1].last = 1;
        end else if (s < 0) begin
          expect_outcome(ST_NOT_FOUND, 0, 0, EV_NONE, 0, 0, 0, 1);
        end else begin
          for (int k = 0; k < MAX_KINDS; k++) usage[s][k] = 0;
          expect_outcome(ST_OK, id, 0, EV_RESET, 0, 0, 0, 1);
        end
      end
      ACT_SYS_TOTAL: begin
        if (kind >= MAX_KINDS)
          expect_outcome(ST_BAD_KIND, 0, 0, EV_NONE, 0, 0, 0, 1);
        else
          expect_outcome(ST_OK, 0, 0, EV_NONE, sys_total[kind], 0, 0, 1);
      end
      default: expect_outcome(ST_OK, 0, 0, EV_NONE, 0, 0, 0, 1);
    endcase
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
  endtask

  task automatic compare_result();
    outcome_t o;
    if (awaited.size() == 0) begin
      report("unexpected result item", m_tdata[31:0], 0);
    end else begin
      o = awaited.pop_front();
      checked++;
      if (m_tdata[2:0]    !== o.status)    report("status", m_tdata[2:0], o.status);
      if (m_tdata[34:3]   !== o.ev_client) report("event_client", m_tdata[34:3], o.ev_client);
      if (m_tdata[37:35]  !== o.ev_kind)   report("event_kind", m_tdata[37:35], o.ev_kind);
      if (m_tdata[39:38]  !== o.ev_res)    report("event_res", m_tdata[39:38], o.ev_res);
      if (m_tdata[71:40]  !== o.usage)     report("usage_value", m_tdata[71:40], o.usage);
      if (m_tdata[103:72] !== o.quota)     report("quota_value", m_tdata[103:72], o.quota);
      if (m_tdata[104]    !== o.fits)      report("fits", m_tdata[104], o.fits);
      if (m_tlast         !== o.last)      report("last", m_tlast, o.last);
    end
  endtask

  initial begin
    errors = 0;
    checked = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      awaited.delete();
      for (int k = 0; k < MAX_KINDS; k++) begin
        dflt_quota[k] = RESET_QUOTA[k];
        sys_total[k] = 0;
      end
      warn_pct = RESET_WARN;
      for (int i = 0; i < SLOTS; i++) used[i] = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WARN) warn_pct = cfg_data[6:0];
        else dflt_quota[cfg_index] = cfg_data;
      end
      if (m_tvalid && m_tready) compare_result();
      if (s_tvalid && s_tready)
        account_command(s_tdata[3:0], s_tdata[35:4], s_tdata[38:36], s_tdata[70:39]);
    end
    pending <= awaited.size();
  end

endmodule

// File: tb/sv/per_client_quota_accounting_table_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_client_quota_accounting_table_unit_test: top of the quota table bench
// Drives directed and random accounting commands under several idle and
// stall patterns and register settings; a checker module judges the results.
// ----------------------------------------------------------------------------
module per_client_quota_accounting_table_unit_test;
  import pcq_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          POOL_SIZE    = 24;
  localparam int          DRAIN_CYCLES = 40;
  localparam logic [3:0]  ACT_UNUSED_LO = 4'd9;
  localparam logic [3:0]  ACT_UNUSED_HI = 4'd15;
  localparam logic [2:0]  KIND_MEM    = 3'd0;
  localparam logic [2:0]  KIND_CPU    = 3'd1;
  localparam logic [2:0]  KIND_HANDLE = 3'd5;
  localparam logic [2:0]  KIND_BAD    = 3'd7;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [111:0] m_tdata;
  logic         m_tlast;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  int          errors, pending, checked;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          sent = 0;
  int          cycles = 0;
  logic [31:0] pool[POOL_SIZE];

  per_client_quota_accounting_table_unit uut (.*);

  pcq_quota_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tlast, .cfg_we, .cfg_index, .cfg_data, .errors, .pending, .checked
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(logic [3:0] act, logic [31:0] id, logic [2:0] kind,
                           logic [31:0] amount);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, amount, kind, id, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Registers may only change once the table has gone quiet.
  task automatic write_defaults(logic [31:0] q[MAX_KINDS], logic [6:0] warn);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int k = 0; k <= MAX_KINDS; k++) begin
      cfg_we <= 1;
      cfg_index <= k[2:0];
      cfg_data <= (k == CFG_WARN) ? {25'd0, warn} : q[k];
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  task automatic random_command();
    int r;
    logic [3:0]  act;
    logic [31:0] id;
    logic [2:0]  kind;
    logic [31:0] amount;
    r = $urandom_range(99);
    if      (r < 15) act = ACT_REGISTER;
    else if (r < 20) act = ACT_UNREGISTER;
    else if (r < 30) act = ACT_SET_QUOTA;
    else if (r < 55) act = ACT_REQUEST;
    else if (r < 67) act = ACT_RELEASE;
    else if (r < 74) act = ACT_QUERY;
    else if (r < 81) act = ACT_CHECK;
    else if (r < 88) act = ACT_RESET;
    else if (r < 95) act = ACT_SYS_TOTAL;
    else act = 4'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
    r = $urandom_range(99);
    if (r < 85) id = pool[$urandom_range(POOL_SIZE - 1)];
    else if (r < 95) id = $urandom;
    else id = 0;
    // Some resets of one client are turned into resets of all clients, which yield a burst of results.
    if (act == ACT_RESET && id != 0 && $urandom_range(9) == 0) id = 0;
    kind = ($urandom_range(9) == 0) ? KIND_BAD : 3'($urandom_range(MAX_KINDS - 1));
    r = $urandom_range(99);
    if (r < 35) amount = $urandom_range(15);
    else if (r < 60) amount = $urandom_range(200000);
    else if (r < 80) amount = $urandom_range(12000000);
    else if (r < 92) amount = $urandom;
    else amount = 32'hFFFF_FFFF;
    send_item(act, id, kind, amount);
  endtask

  initial begin
    logic [31:0] q[MAX_KINDS];
    logic [31:0] a, b;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom | 32'd1;
    pool[POOL_SIZE - 1] = 32'hFFFF_FFFF;
    a = pool[0];
    b = pool[1];
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part with default registers and no idling.
    send_item(ACT_RESET, 0, KIND_MEM, 0);
    send_item(ACT_REGISTER, a, KIND_MEM, 0);
    send_item(ACT_REGISTER, a, KIND_MEM, 0);
    send_item(ACT_UNREGISTER, b, KIND_MEM, 0);
    send_item(ACT_REQUEST, a, KIND_HANDLE, 6);
    send_item(ACT_REQUEST, a, KIND_HANDLE, 1);
    send_item(ACT_REQUEST, a, KIND_HANDLE, 5);
    send_item(ACT_REQUEST, a, KIND_BAD, 1);
    send_item(ACT_SET_QUOTA, a, KIND_MEM, 32'hFFFF_FFFF);
    send_item(ACT_REQUEST, a, KIND_MEM, 32'hFFFF_FFFF);
    send_item(ACT_REQUEST, a, KIND_MEM, 1);
    send_item(ACT_RELEASE, a, KIND_CPU, 5);
    send_item(ACT_RELEASE, a, KIND_MEM, 32'h10);
    send_item(ACT_QUERY, a, KIND_MEM, 0);
    send_item(ACT_CHECK, a, KIND_HANDLE, 1);
    send_item(ACT_SYS_TOTAL, 0, KIND_MEM, 0);
    send_item(ACT_SYS_TOTAL, 0, KIND_BAD, 0);
    send_item(ACT_RESET, a, KIND_MEM, 0);
    send_item(ACT_REGISTER, b, KIND_MEM, 0);
    send_item(ACT_RESET, 0, KIND_MEM, 0);
    send_item(ACT_UNUSED_LO, a, KIND_MEM, 0);
    send_item(ACT_UNUSED_HI, 32'hFFFF_FFFF, KIND_BAD, 32'hFFFF_FFFF);
    send_item(ACT_UNREGISTER, a, KIND_MEM, 0);
    send_item(ACT_QUERY, a, KIND_MEM, 0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          for (int k = 0; k < MAX_KINDS; k++) q[k] = 32'hFFFF_FFFF;
          write_defaults(q, 7'd100);
          idle_pct = 84; stall_pct = 0;
        end
        2: begin
          for (int k = 0; k < MAX_KINDS; k++) q[k] = 0;
          write_defaults(q, 7'd0);
          idle_pct = 0; stall_pct = 84;
        end
        default: begin
          for (int k = 0; k < MAX_KINDS; k++)
            q[k] = ($urandom_range(1) == 0) ? 32'($urandom_range(64)) : $urandom;
          write_defaults(q, 7'($urandom_range(100)));
          idle_pct = 15; stall_pct = 15;
        end
      endcase
      for (int i = 0; i < 37; i++) begin
        random_command();
        // Hold the sender back once until the table has answered everything.
        if (phase == 2 && i == 18) drain();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands over four register settings and idle patterns.", sent);
    $display("Compared %0d result items.", checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
